>>> hdl/spc_pkg.sv
// spc_pkg: shared types, constants and helpers for the site pattern counter.
// Used by spc_column, spc_table and site_pattern_counter_unit; no dependencies.
package spc_pkg;

    localparam int SPC_PATTERN_SLOTS = 1024;
    localparam int SPC_MAX_SPECIES   = 32;
    localparam int SPC_COUNT_BITS    = 32;

    localparam int BASE_BITS  = 2;
    localparam int PATTERN_W  = 64;
    localparam int BASES_W    = 6;
    localparam int READ_IDX_W = 10;
    localparam int OUT_CNT_W  = 32;
    localparam int DISTINCT_W = 11;

    localparam logic [BASES_W-1:0] BASES_MAX = '1;

    localparam logic [7:0] CH_LA = 8'h61;
    localparam logic [7:0] CH_LC = 8'h63;
    localparam logic [7:0] CH_LG = 8'h67;
    localparam logic [7:0] CH_LT = 8'h74;
    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UC = 8'h43;
    localparam logic [7:0] CH_UG = 8'h47;
    localparam logic [7:0] CH_UT = 8'h54;

    localparam logic [BASE_BITS-1:0] BASE_A = 2'd0;
    localparam logic [BASE_BITS-1:0] BASE_C = 2'd1;
    localparam logic [BASE_BITS-1:0] BASE_G = 2'd2;
    localparam logic [BASE_BITS-1:0] BASE_T = 2'd3;

    typedef enum logic [2:0] {
        ST_MATCH   = 3'd0,
        ST_ADDED   = 3'd1,
        ST_INVALID = 3'd2,
        ST_TOO_MANY = 3'd3,
        ST_FULL    = 3'd4,
        ST_READ_OK = 3'd5,
        ST_UNUSED  = 3'd6
    } t_status;

    typedef struct packed {
        logic                  func;
        logic [7:0]            base_char;
        logic                  end_of_column;
        logic [READ_IDX_W-1:0] read_index;
    } t_in_item;

    typedef struct packed {
        t_status               status;
        logic [PATTERN_W-1:0]  pattern;
        logic [OUT_CNT_W-1:0]  pattern_count;
        logic [READ_IDX_W-1:0] entry_index;
        logic [DISTINCT_W-1:0] distinct_patterns;
    } t_out_item;

    typedef struct packed {
        logic over;
        logic bad;
    } t_col_flags;

    typedef struct packed {
        logic pat;
        logic cnt;
    } t_wr_en;

    typedef struct packed {
        logic                 ok;
        logic [BASE_BITS-1:0] code;
    } t_base;

    function automatic t_base base_decode(input logic [7:0] ch);
        t_base b;
        b.ok   = 1'b1;
        b.code = BASE_A;
        case (ch)
            CH_LA, CH_UA: b.code = BASE_A;
            CH_LC, CH_UC: b.code = BASE_C;
            CH_LG, CH_UG: b.code = BASE_G;
            CH_LT, CH_UT: b.code = BASE_T;
            default:      b.ok = 1'b0;
        endcase
        return b;
    endfunction

endpackage

>>> hdl/site_pattern_counter_unit.sv
// site_pattern_counter_unit: histogram of distinct alignment-column patterns.
// Depends on spc_pkg, spc_column and spc_table.
//
// Input channel (i_in_valid / o_in_stall / i_in_item): func 0 pushes one species
// character of the current column, end_of_column marks the last one; func 1 reads
// a stored table entry. Output channel (o_out_valid / i_out_stall / o_out_item)
// carries one item per column end and per read.
// A character without column end is accepted and gives no item.
// After a column end is accepted, the shared 64-bit comparator walks the table
// one entry a cycle through the registered read port until a hit or until every
// used entry is compared (then an append, or ST_FULL); S_EMIT then loads the
// output register. Invalid and oversize columns skip the walk; reads use S_READ.
// o_in_stall is high while a column end or read is in work.
// While the receiver stalls, a waiting output item holds and new characters are
// still accepted; a further item waits in the sequencer until the register frees.
// Reset (synchronous, active low) empties the table count and column state;
// table memory contents are not cleared, only entries below the count are read.
module site_pattern_counter_unit #(
    parameter int PATTERN_SLOTS = spc_pkg::SPC_PATTERN_SLOTS,
    parameter int MAX_SPECIES   = spc_pkg::SPC_MAX_SPECIES,
    parameter int COUNT_BITS    = spc_pkg::SPC_COUNT_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  spc_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output spc_pkg::t_out_item o_out_item
);
    import spc_pkg::*;

    localparam int AW = $clog2(PATTERN_SLOTS);
    localparam int EW = $clog2(PATTERN_SLOTS + 1);
    localparam int IW = (EW > READ_IDX_W) ? EW : READ_IDX_W;
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_READ   = 4'b0100,
        S_EMIT   = 4'b1000
    } t_state;

    t_state                r_state, n_state;
    logic [EW-1:0]         r_used, n_used;
    logic [EW-1:0]         r_scan, n_scan;
    logic [AW-1:0]         r_chk, n_chk;
    logic                  r_pend, n_pend;
    logic [PATTERN_W-1:0]  r_pat, n_pat;
    logic [READ_IDX_W-1:0] r_ridx, n_ridx;
    logic                  r_rd_ok, n_rd_ok;
    t_out_item             r_res, n_res;
    logic                  r_out_valid, n_out_valid;
    t_out_item             r_out, n_out;

    logic                  in_acc;
    logic                  push;
    logic [PATTERN_W-1:0]  col_pat;
    t_col_flags            col_flags;
    logic [AW-1:0]         rd_addr;
    logic [PATTERN_W-1:0]  rd_pat;
    logic [COUNT_BITS-1:0] rd_cnt;
    t_wr_en                wr_en;
    logic [AW-1:0]         wr_addr;
    logic [COUNT_BITS-1:0] wr_cnt;
    logic [COUNT_BITS-1:0] inc_cnt;
    logic [IW-1:0]         ridx_w;
    logic                  hit;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign push        = in_acc && !i_in_item.func;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    spc_column #(
        .MAX_SPECIES(MAX_SPECIES)
    ) u_column (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_char   (i_in_item.base_char),
        .i_eoc    (i_in_item.end_of_column),
        .o_pattern(col_pat),
        .o_flags  (col_flags)
    );

    spc_table #(
        .PATTERN_SLOTS(PATTERN_SLOTS),
        .COUNT_BITS   (COUNT_BITS)
    ) u_table (
        .i_clk    (i_clk),
        .i_rd_addr(rd_addr),
        .o_rd_pat (rd_pat),
        .o_rd_cnt (rd_cnt),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_pat (r_pat),
        .i_wr_cnt (wr_cnt)
    );

    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_scan      = r_scan;
        n_chk       = r_chk;
        n_pend      = r_pend;
        n_pat       = r_pat;
        n_ridx      = r_ridx;
        n_rd_ok     = r_rd_ok;
        n_res       = r_res;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        ridx_w      = IW'(i_in_item.read_index);
        rd_addr     = r_scan[AW-1:0];
        wr_en       = '0;
        wr_addr     = r_used[AW-1:0];
        inc_cnt     = (&rd_cnt) ? rd_cnt : rd_cnt + CNT_ONE;
        wr_cnt      = CNT_ONE;
        hit         = r_pend && (rd_pat == r_pat);

        case (r_state)
            S_IDLE: begin
                rd_addr = ridx_w[AW-1:0];
                if (in_acc && i_in_item.func) begin
                    n_ridx  = i_in_item.read_index;
                    n_rd_ok = ridx_w < IW'(r_used);
                    n_state = S_READ;
                end else if (push && i_in_item.end_of_column) begin
                    n_res                   = '0;
                    n_res.distinct_patterns = DISTINCT_W'(r_used);
                    if (col_flags.over) begin
                        n_res.status = ST_TOO_MANY;
                        n_state      = S_EMIT;
                    end else if (col_flags.bad) begin
                        n_res.status = ST_INVALID;
                        n_state      = S_EMIT;
                    end else begin
                        n_pat   = col_pat;
                        n_scan  = '0;
                        n_pend  = 1'b0;
                        n_state = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                n_res.pattern           = r_pat;
                n_res.distinct_patterns = DISTINCT_W'(r_used);
                if (hit) begin
                    wr_en.cnt           = 1'b1;
                    wr_addr             = r_chk;
                    wr_cnt              = inc_cnt;
                    n_res.status        = ST_MATCH;
                    n_res.pattern_count = OUT_CNT_W'(64'(inc_cnt));
                    n_res.entry_index   = READ_IDX_W'(r_chk);
                    n_state             = S_EMIT;
                end else if (r_scan < r_used) begin
                    n_chk  = r_scan[AW-1:0];
                    n_pend = 1'b1;
                    n_scan = r_scan + EW'(1);
                end else if (r_used == EW'(PATTERN_SLOTS)) begin
                    n_res.status        = ST_FULL;
                    n_res.pattern_count = '0;
                    n_res.entry_index   = '0;
                    n_state             = S_EMIT;
                end else begin
                    wr_en.pat               = 1'b1;
                    wr_en.cnt               = 1'b1;
                    n_used                  = r_used + EW'(1);
                    n_res.status            = ST_ADDED;
                    n_res.pattern_count     = OUT_CNT_W'(64'(CNT_ONE));
                    n_res.entry_index       = READ_IDX_W'(r_used);
                    n_res.distinct_patterns = DISTINCT_W'(r_used + EW'(1));
                    n_state                 = S_EMIT;
                end
            end
            S_READ: begin
                n_res.entry_index       = r_ridx;
                n_res.distinct_patterns = DISTINCT_W'(r_used);
                if (r_rd_ok) begin
                    n_res.status        = ST_READ_OK;
                    n_res.pattern       = rd_pat;
                    n_res.pattern_count = OUT_CNT_W'(64'(rd_cnt));
                end else begin
                    n_res.status        = ST_UNUSED;
                    n_res.pattern       = '0;
                    n_res.pattern_count = '0;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan  <= n_scan;
        r_chk   <= n_chk;
        r_pat   <= n_pat;
        r_ridx  <= n_ridx;
        r_rd_ok <= n_rd_ok;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= EW'(PATTERN_SLOTS))
        else $error("pattern count beyond table depth");

    a_wr_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en.pat || wr_en.cnt) |-> (r_state == S_SEARCH))
        else $error("table write outside search");

    a_append_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en.pat |=> (r_used == $past(r_used) + EW'(1)))
        else $error("append did not advance pattern count");

    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && (!r_out_valid || !i_out_stall)) |=>
            (o_out_valid && r_state == S_IDLE))
        else $error("result not loaded from emit");

    a_pend_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH && r_pend) |-> (r_scan != '0))
        else $error("compare pending without issued read");

endmodule

>>> hdl/spc_column.sv
// spc_column: assembles one column's pattern word, species count and invalid flag.
// Depends on spc_pkg. Shows the column state as it stands after the current character.
module spc_column #(
    parameter int MAX_SPECIES = spc_pkg::SPC_MAX_SPECIES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic [7:0]                     i_char,
    input  logic                           i_eoc,
    output logic [spc_pkg::PATTERN_W-1:0]  o_pattern,
    output spc_pkg::t_col_flags            o_flags
);
    import spc_pkg::*;

    logic [PATTERN_W-1:0] r_pattern, n_pattern;
    logic [BASES_W-1:0]   r_bases, n_bases;
    logic                 r_invalid, n_invalid;
    t_base                base;

    always_comb begin
        base      = base_decode(i_char);
        n_pattern = base.ok ? {r_pattern[PATTERN_W-BASE_BITS-1:0], base.code} : r_pattern;
        n_invalid = r_invalid | ~base.ok;
        n_bases   = (r_bases == BASES_MAX) ? r_bases : r_bases + BASES_W'(1);
    end

    assign o_pattern    = n_pattern;
    assign o_flags.over = n_bases > BASES_W'(MAX_SPECIES);
    assign o_flags.bad  = n_invalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_bases   <= '0;
            r_invalid <= 1'b0;
        end else if (i_push) begin
            if (i_eoc) begin
                r_pattern <= '0;
                r_bases   <= '0;
                r_invalid <= 1'b0;
            end else begin
                r_pattern <= n_pattern;
                r_bases   <= n_bases;
                r_invalid <= n_invalid;
            end
        end
    end

endmodule

>>> hdl/spc_table.sv
// spc_table: pattern and count storage, one write port and one registered read port.
// Depends on spc_pkg for the write enable struct and the pattern width.
module spc_table #(
    parameter int PATTERN_SLOTS = spc_pkg::SPC_PATTERN_SLOTS,
    parameter int COUNT_BITS    = spc_pkg::SPC_COUNT_BITS,
    localparam int AW           = $clog2(PATTERN_SLOTS)
) (
    input  logic                          i_clk,
    input  logic [AW-1:0]                 i_rd_addr,
    output logic [spc_pkg::PATTERN_W-1:0] o_rd_pat,
    output logic [COUNT_BITS-1:0]         o_rd_cnt,
    input  spc_pkg::t_wr_en               i_wr_en,
    input  logic [AW-1:0]                 i_wr_addr,
    input  logic [spc_pkg::PATTERN_W-1:0] i_wr_pat,
    input  logic [COUNT_BITS-1:0]         i_wr_cnt
);
    import spc_pkg::*;

    logic [PATTERN_W-1:0]  r_pat_mem [PATTERN_SLOTS];
    logic [COUNT_BITS-1:0] r_cnt_mem [PATTERN_SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_wr_en.pat) begin
            r_pat_mem[i_wr_addr] <= i_wr_pat;
        end
        if (i_wr_en.cnt) begin
            r_cnt_mem[i_wr_addr] <= i_wr_cnt;
        end
        o_rd_pat <= r_pat_mem[i_rd_addr];
        o_rd_cnt <= r_cnt_mem[i_rd_addr];
    end

endmodule

>>> tb/spc_result_checker.sv
`timescale 1ns / 100ps
// spc_result_checker: watches both channels of site_pattern_counter_unit, predicts
// each result item from the accepted input items and compares field by field.
// Depends on spc_pkg for the item types, status codes and character constants.
module spc_result_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  spc_pkg::t_in_item  i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  spc_pkg::t_out_item i_out_item,
    output int                 o_mismatches,
    output int                 o_results_due
);
    import spc_pkg::*;

    logic [PATTERN_W-1:0] col_pattern;
    logic [BASES_W-1:0]   col_bases;
    logic                 col_invalid;
    logic [PATTERN_W-1:0] pattern_store [SPC_PATTERN_SLOTS];
    logic [OUT_CNT_W-1:0] tally_store [SPC_PATTERN_SLOTS];
    int                   stored_patterns;
    t_out_item            expected_results [$];
    int                   mismatch_total = 0;

    assign o_mismatches = mismatch_total;

    task automatic flag_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("ERROR at %0t: %s got 0x%0h, expected 0x%0h", $realtime, field, got, want);
        mismatch_total++;
    endtask

    task automatic tally_item(input t_in_item it);
        t_out_item            res;
        logic [BASE_BITS-1:0] code;
        logic                 known;
        logic [PATTERN_W-1:0] pat;
        logic                 over;
        logic                 bad;
        logic                 hit;
        res = '0;
        res.distinct_patterns = DISTINCT_W'(stored_patterns);
        if (it.func) begin
            res.entry_index = it.read_index;
            if (it.read_index < stored_patterns) begin
                res.status        = ST_READ_OK;
                res.pattern       = pattern_store[it.read_index];
                res.pattern_count = tally_store[it.read_index];
            end else begin
                res.status = ST_UNUSED;
            end
            expected_results = {expected_results, res};
            return;
        end
        known = 1'b1;
        code  = BASE_A;
        case (it.base_char)
            CH_LA, CH_UA: code = BASE_A;
            CH_LC, CH_UC: code = BASE_C;
            CH_LG, CH_UG: code = BASE_G;
            CH_LT, CH_UT: code = BASE_T;
            default:      known = 1'b0;
        endcase
        if (known)
            col_pattern = {col_pattern[PATTERN_W-BASE_BITS-1:0], code};
        else
            col_invalid = 1'b1;
        if (col_bases != BASES_MAX)
            col_bases++;
        if (!it.end_of_column)
            return;
        pat         = col_pattern;
        over        = col_bases > SPC_MAX_SPECIES;
        bad         = col_invalid;
        col_pattern = '0;
        col_bases   = '0;
        col_invalid = 1'b0;
        if (over) begin
            res.status = ST_TOO_MANY;
        end else if (bad) begin
            res.status = ST_INVALID;
        end else begin
            hit = 1'b0;
            for (int k = 0; k < stored_patterns && !hit; k++) begin
                if (pattern_store[k] === pat) begin
                    hit = 1'b1;
                    if (tally_store[k] != '1)
                        tally_store[k]++;
                    res.status        = ST_MATCH;
                    res.pattern       = pat;
                    res.pattern_count = tally_store[k];
                    res.entry_index   = READ_IDX_W'(k);
                end
            end
            if (!hit && stored_patterns >= SPC_PATTERN_SLOTS) begin
                res.status  = ST_FULL;
                res.pattern = pat;
            end else if (!hit) begin
                pattern_store[stored_patterns] = pat;
                tally_store[stored_patterns]   = OUT_CNT_W'(1);
                res.status        = ST_ADDED;
                res.pattern       = pat;
                res.pattern_count = OUT_CNT_W'(1);
                res.entry_index   = READ_IDX_W'(stored_patterns);
                stored_patterns++;
            end
        end
        res.distinct_patterns = DISTINCT_W'(stored_patterns);
        expected_results = {expected_results, res};
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            col_pattern     = '0;
            col_bases       = '0;
            col_invalid     = 1'b0;
            stored_patterns = 0;
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    flag_mismatch("unexpected result item, status", i_out_item.status, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_item.status !== want.status)
                        flag_mismatch("status", i_out_item.status, want.status);
                    if (i_out_item.pattern !== want.pattern)
                        flag_mismatch("pattern", i_out_item.pattern, want.pattern);
                    if (i_out_item.pattern_count !== want.pattern_count)
                        flag_mismatch("pattern_count", i_out_item.pattern_count,
                                      want.pattern_count);
                    if (i_out_item.entry_index !== want.entry_index)
                        flag_mismatch("entry_index", i_out_item.entry_index,
                                      want.entry_index);
                    if (i_out_item.distinct_patterns !== want.distinct_patterns)
                        flag_mismatch("distinct_patterns", i_out_item.distinct_patterns,
                                      want.distinct_patterns);
                end
            end
            if (i_in_valid && !i_in_stall)
                tally_item(i_in_item);
        end
        o_results_due <= expected_results.size();
    end

endmodule

>>> tb/site_pattern_counter_unit_tb.sv
`timescale 1ns / 100ps
// site_pattern_counter_unit_tb: drives columns and table reads into the block with
// random idling on both sides; spc_result_checker predicts and compares the items.
// Depends on spc_pkg, site_pattern_counter_unit and spc_result_checker.
module site_pattern_counter_unit_tb;
    import spc_pkg::*;

    localparam int RANDOM_ITEMS  = 950;
    localparam int QUIET_LIMIT   = 8000;
    localparam int SETTLE_CYCLES = 20;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_item;

    int          mismatches;
    int          results_due;
    bit          idling_on;
    int          stall_left   = 0;
    int          quiet_cycles = 0;
    int          items_sent   = 0;
    logic [63:0] seen_patterns [$];
    int          seen_lengths [$];

    site_pattern_counter_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    spc_result_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_in_item     (i_in_item),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_out_item    (o_out_item),
        .o_mismatches  (mismatches),
        .o_results_due (results_due)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // receiver: random stall bursts, only while idling is on
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
        end else if (idling_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 15);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_in_item char_item(input logic [7:0] ch, input logic last);
        t_in_item it;
        it.func          = 1'b0;
        it.base_char     = ch;
        it.end_of_column = last;
        it.read_index    = READ_IDX_W'($urandom_range(0, 1023));
        return it;
    endfunction

    function automatic t_in_item read_item(input logic [READ_IDX_W-1:0] idx);
        t_in_item it;
        it.func          = 1'b1;
        it.base_char     = 8'($urandom_range(0, 255));
        it.end_of_column = 1'($urandom_range(0, 1));
        it.read_index    = idx;
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        if (idling_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_in_item  <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    // first species is sent first and lands in the highest bits
    task automatic send_column(input int len, input logic [63:0] pat, input bit noisy);
        logic [1:0] code;
        logic [7:0] ch;
        logic       upper;
        for (int j = len - 1; j >= 0; j--) begin
            code  = (j < 32) ? pat[2*j +: 2] : 2'($urandom_range(0, 3));
            upper = 1'($urandom_range(0, 1));
            case (code)
                BASE_A:  ch = upper ? CH_UA : CH_LA;
                BASE_C:  ch = upper ? CH_UC : CH_LC;
                BASE_G:  ch = upper ? CH_UG : CH_LG;
                default: ch = upper ? CH_UT : CH_LT;
            endcase
            if (noisy && $urandom_range(0, 7) == 0)
                ch = 8'($urandom_range(0, 255));
            if (j != len - 1 && $urandom_range(0, 15) == 0)
                send_item(read_item(READ_IDX_W'($urandom_range(0, 1023))));
            send_item(char_item(ch, j == 0));
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (results_due != 0);
    endtask

    initial begin
        t_in_item    flagged_read;
        int          len;
        int          pick;
        int          extra;
        int          directed_items;
        logic [63:0] pat;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_out_stall = 1'b0;
        idling_on   = 1'b1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: append, case folding, reads, read inside a column, bad characters
        send_item(char_item(CH_LA, 1'b1));
        send_item(char_item(CH_UA, 1'b1));
        send_item(char_item(CH_LC, 1'b0));
        send_item(char_item(CH_UG, 1'b0));
        send_item(char_item(CH_LT, 1'b1));
        send_item(read_item(10'd0));
        send_item(read_item(10'd1));
        send_item(read_item(10'd1023));
        send_item(char_item(CH_UT, 1'b0));
        flagged_read               = read_item(10'd1);
        flagged_read.end_of_column = 1'b1;
        flagged_read.base_char     = 8'hFF;
        send_item(flagged_read);
        send_item(char_item(CH_LG, 1'b1));
        send_item(char_item(CH_UC, 1'b0));
        send_item(char_item(8'h00, 1'b0));
        send_item(char_item(8'hFF, 1'b0));
        send_item(char_item(CH_LA, 1'b1));
        send_item(char_item(CH_UC, 1'b1));
        send_item(read_item(10'd2));
        send_item(read_item(10'd3));
        drain_results();
        directed_items = items_sent;

        while (items_sent < directed_items + RANDOM_ITEMS) begin
            if ($urandom_range(0, 19) == 0)
                idling_on = !idling_on;
            if ($urandom_range(0, 6) == 0) begin
                if ($urandom_range(0, 1) == 1)
                    send_item(read_item(READ_IDX_W'($urandom_range(0, 1023))));
                else
                    send_item(read_item(READ_IDX_W'($urandom_range(0, 127))));
            end else if (seen_lengths.size() != 0 && $urandom_range(0, 2) == 0) begin
                pick  = $urandom_range(0, seen_lengths.size() - 1);
                len   = seen_lengths[pick];
                extra = (len <= 30) ? $urandom_range(0, 2) : 0;
                send_column(len + extra, seen_patterns[pick], $urandom_range(0, 3) == 0);
            end else begin
                case ($urandom_range(0, 9))
                    0:       len = $urandom_range(33, 70);
                    1:       len = $urandom_range(31, 32);
                    default: len = $urandom_range(1, 20);
                endcase
                pat = {$urandom, $urandom};
                if (len <= 32) begin
                    pat &= ~(64'hFFFF_FFFF_FFFF_FFFF << (2 * len));
                    seen_patterns = {seen_patterns, pat};
                    seen_lengths  = {seen_lengths, len};
                    if (seen_lengths.size() > 64) begin
                        void'(seen_patterns.pop_front());
                        void'(seen_lengths.pop_front());
                    end
                end
                send_column(len, pat, $urandom_range(0, 3) == 0);
            end
        end
        drain_results();

        // no idling: new and repeated patterns back to back, then reads
        idling_on = 1'b0;
        for (int k = 0; k < 8; k++)
            send_column(8, 64'hF000 + 64'(k & 3), 1'b0);
        send_column(5, 64'd5, 1'b0);
        send_column(1, 64'd0, 1'b0);
        send_item(read_item(10'd0));
        send_item(read_item(10'd1023));
        send_item(read_item(READ_IDX_W'($urandom_range(0, 1023))));
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && results_due == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> filelist.f
hdl/spc_pkg.sv
hdl/spc_column.sv
hdl/spc_table.sv
hdl/site_pattern_counter_unit.sv
tb/spc_result_checker.sv
tb/site_pattern_counter_unit_tb.sv
